@@ rtl/lrd_pkg.sv @@
// Shared types and constants for the load record deframer.
// Used by the configuration registers, the record parser, the top level
// and the port checker. Depends on nothing.
package lrd_pkg;

  localparam logic [7:0] ID_LOAD   = 8'h02;
  localparam logic [7:0] ID_FILL   = 8'h00;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ADDR_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 2'd1;

  localparam logic [ADDR_W-1:0] WINDOW_LOW_RST  = 16'h0000;
  localparam logic [ADDR_W-1:0] WINDOW_HIGH_RST = 16'hFFFF;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] high;
  } window_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } result_t;

endpackage

@@ rtl/lrd_cfg.sv @@
// Window configuration registers of the load record deframer.
// Depends on lrd_pkg.
module lrd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrd_pkg::ADDR_W-1:0]     cfg_wdata,
  output lrd_pkg::window_t               window
);
  import lrd_pkg::*;

  window_t window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r.low  <= WINDOW_LOW_RST;
      window_r.high <= WINDOW_HIGH_RST;
    end else if (cfg_we) begin
      // Writes to indexes outside the register list are dropped.
      if (cfg_index == CFG_WINDOW_LOW) begin
        window_r.low <= cfg_wdata;
      end
      if (cfg_index == CFG_WINDOW_HIGH) begin
        window_r.high <= cfg_wdata;
      end
    end
  end

  assign window = window_r;

endmodule

@@ rtl/lrd_parse.sv @@
// Record parser: phase state machine, record address, byte count and
// window flag, with the result for the byte being stepped.
// Depends on lrd_pkg.
module lrd_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  lrd_pkg::window_t  window,
  output logic              res_valid,
  output lrd_pkg::result_t  res
);
  import lrd_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT_ID,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_LENGTH,
    PH_DATA,
    PH_STOPPED
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        left_r, left_nxt;
  logic              in_win_r, in_win_nxt;
  logic [ADDR_W-1:0] full_addr;
  logic [7:0]        left_dec;

  assign full_addr = {addr_r[ADDR_W-1:8], byte_in};
  assign left_dec  = left_r - 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    addr_nxt   = addr_r;
    left_nxt   = left_r;
    in_win_nxt = in_win_r;
    res_valid  = 1'b0;
    res.kind   = KIND_DATA;
    res.data   = byte_in;
    unique case (phase_r)
      PH_STOPPED: begin
        phase_nxt = PH_STOPPED;
      end
      PH_ADDR_HI: begin
        addr_nxt  = {byte_in, 8'h00};
        phase_nxt = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        // The window is sampled once per record, on the low address byte.
        addr_nxt   = full_addr;
        in_win_nxt = (full_addr >= window.low) && (full_addr <= window.high);
        phase_nxt  = PH_LENGTH;
      end
      PH_LENGTH: begin
        left_nxt  = byte_in;
        phase_nxt = (byte_in == 8'd0) ? PH_WAIT_ID : PH_DATA;
      end
      PH_DATA: begin
        left_nxt  = left_dec;
        phase_nxt = (left_dec == 8'd0) ? PH_WAIT_ID : PH_DATA;
        res_valid = in_win_r;
      end
      default: begin
        if (byte_in == ID_FILL) begin
          phase_nxt = PH_WAIT_ID;
        end else if (byte_in == ID_LOAD) begin
          phase_nxt = PH_ADDR_HI;
        end else begin
          phase_nxt = PH_STOPPED;
          res_valid = 1'b1;
          res.kind  = KIND_STOP;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT_ID;
      addr_r   <= '0;
      left_r   <= '0;
      in_win_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      addr_r   <= addr_nxt;
      left_r   <= left_nxt;
      in_win_r <= in_win_nxt;
    end
  end

endmodule

@@ rtl/load_record_deframer_range_filter.sv @@
// Load record deframer with a start-address window filter. The block takes
// one byte per transaction on the input channel and parses load records: an
// id byte 0x02, the start address high and low bytes, a length byte and
// that many data bytes, with zero bytes between records skipped. Data bytes
// of a record whose start address lies in [window_low, window_high] leave
// on the result channel with result kind 0; the window is sampled when the
// address low byte is parsed. Any other id byte gives one result of kind 1
// carrying that byte, after which all input is taken and dropped until
// reset. The block sustains one byte per clock while out_stall is low: a
// byte is captured in an input register, parsed by a single level of
// phase logic once the output register is free, and its result lands in
// an output register, so a new byte is accepted while a finished result
// still waits downstream. Each result passes the input register, then the
// output register. The user must write window registers through the cfg
// port only while no byte is in flight; the block does not enforce this.
// Depends on lrd_pkg, lrd_cfg and lrd_parse.
module load_record_deframer_range_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input byte channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_result_kind,
  output logic [7:0]                     out_byte,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [lrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrd_pkg::ADDR_W-1:0]     cfg_wdata
);
  import lrd_pkg::*;

  window_t    window;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_adv;
  logic       res_valid;
  result_t    res;
  logic       out_valid_r;
  result_t    out_r;
  logic       out_free;

  lrd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .window    (window)
  );

  // The output register is free when empty or being drained this cycle.
  // The held byte moves through the parser only then, so a result is never
  // dropped; bytes that yield no result move under the same rule.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  lrd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .byte_in   (s1_byte_r),
    .window    (window),
    .res_valid (res_valid),
    .res       (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid && out_free) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_r.kind;
  assign out_byte        = out_r.data;

endmodule

@@ rtl/lrd_checker.sv @@
// Port-level checker for the load record deframer, bound to the top level.
// Depends on lrd_pkg and load_record_deframer_range_filter.
module lrd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_result_kind,
  input logic [7:0] out_byte
);
  import lrd_pkg::*;

  // A result held under stall keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_result_kind))
    else $error("result changed while stalled");

  // The input side only backs up when a result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // A stop result never carries a fill byte or a load id.
  a_stop_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_STOP |->
      out_byte != ID_FILL && out_byte != ID_LOAD)
    else $error("stop result with a legal id byte");

  // Once a stop result is taken, nothing follows it.
  a_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_result_kind == KIND_STOP |=> !out_valid)
    else $error("result after stop");

  // Reset leaves the result channel empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind load_record_deframer_range_filter lrd_checker u_lrd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_byte        (out_byte)
);
